### design/sfla_pkg.sv
// ----------------------------------------------------------------------------
// sfla_pkg
// shared types and constants of the slab free-list allocator
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int FREE_ENTRIES = 64;
  localparam int SLAB_ENTRIES = 32;
  localparam int ADDR_W       = 32;
  localparam int FIDX_W       = $clog2(FREE_ENTRIES);
  localparam int FCNT_W       = FIDX_W + 1;
  localparam int TADDR_W      = FIDX_W + 1;
  localparam int SIDX_W       = $clog2(SLAB_ENTRIES);
  localparam int SCNT_W       = SIDX_W + 1;

  localparam logic [ADDR_W-1:0] BASE_RESET = ADDR_W'(24);
  localparam logic [ADDR_W-1:0] ROUND_MASK = ADDR_W'(255);

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REBUILD = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    TRK_CLEAN   = 2'd0,
    TRK_DIRTY   = 2'd1,
    TRK_INVALID = 2'd2
  } trk_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] len;
    logic [ADDR_W-1:0] start;
  } chunk_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_RD, S_A_CHK, S_A_LAST_RD, S_A_LAST_WR,
    S_A_SLAB0, S_A_SLAB1, S_A_SLAB2, S_A_CALC, S_A_SLAB_WR, S_A_APPEND,
    S_F_SE_RD, S_F_SE_CHK, S_F_S1_GO, S_F_S1_RD, S_F_S1_CHK,
    S_F_S2_GO, S_F_S2_RD, S_F_S2_CHK, S_F_MV_RD, S_F_MV_WR, S_F_FINISH,
    S_R_RD, S_R_CHK,
    S_RESP
  } state_e;

endpackage

### design/sfla_chunk_mem.sv
// ----------------------------------------------------------------------------
// sfla_chunk_mem
// chunk table storage: two tables selected by the top address bit, one write
// and one registered read port
// ----------------------------------------------------------------------------
module sfla_chunk_mem (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [sfla_pkg::TADDR_W-1:0]  waddr_i,
  input  sfla_pkg::chunk_t              wdata_i,
  input  logic [sfla_pkg::TADDR_W-1:0]  raddr_i,
  output sfla_pkg::chunk_t              rdata_o
);
  import sfla_pkg::*;

  chunk_t mem_q [2*FREE_ENTRIES];
  chunk_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/slab_free_list_allocator.sv
// ----------------------------------------------------------------------------
// slab_free_list_allocator
// first-fit free-list allocator over slab space with chunk coalescing
// ----------------------------------------------------------------------------
// one command at a time; each table entry visit is a read state then a check
// state on the single registered read port of the chunk and slab memories
// reset clears counts, tracking state and base (24); tables are not cleared
module slab_free_list_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // command[1:0], block_ref[33:2], block_size[65:34]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // result_ref[31:0], status[33:32]
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);
  import sfla_pkg::*;

  state_e state_q, state_d;
  trk_e   trk_q, trk_d;
  logic [ADDR_W-1:0] base_q;
  logic [FCNT_W-1:0] fcnt_q, fcnt_d, rcnt_q, rcnt_d;
  logic [SCNT_W-1:0] scnt_q, scnt_d;
  logic [FIDX_W-1:0] k_q, k_d, m_q, m_d;
  logic [SIDX_W-1:0] sk_q, sk_d;
  logic              tbl_q, tbl_d;
  logic [ADDR_W-1:0] ref_q, ref_d, size_q, size_d, end_q, end_d;
  logic [ADDR_W-1:0] cur_q, cur_d, prev_q, prev_d, sz_q, sz_d, aref_q, aref_d;
  logic [ADDR_W-1:0] mlen_q, mlen_d, res_q, res_d;
  logic              merged_q, merged_d, se_end_q, se_end_d, se_ref_q, se_ref_d;
  logic              full_q, full_d, chk_q, chk_d;

  logic               cw_we;
  logic [TADDR_W-1:0] cw_addr, cr_addr;
  chunk_t             cw_data, cr_data;

  logic [ADDR_W-1:0] slab_q [SLAB_ENTRIES];
  logic [ADDR_W-1:0] sl_rd_q;
  logic              sw_we;
  logic [SIDX_W-1:0] sw_addr, sr_addr;
  logic [ADDR_W-1:0] sw_data;

  logic [1:0]        s_cmd;
  logic [ADDR_W-1:0] s_ref, s_size;
  logic [FCNT_W-1:0] cnt_sel;
  logic              k_last, sk_last;
  logic [ADDR_W-1:0] diff, rnd;
  logic [ADDR_W:0]   sum;

  assign s_cmd  = s_axis_tdata_i[1:0];
  assign s_ref  = s_axis_tdata_i[33:2];
  assign s_size = s_axis_tdata_i[65:34];

  assign cnt_sel = tbl_q ? rcnt_q : fcnt_q;
  assign k_last  = (FCNT_W'(k_q) + FCNT_W'(1)) == cnt_sel;
  assign sk_last = (SCNT_W'(sk_q) + SCNT_W'(1)) == scnt_q;
  assign diff    = cur_q - prev_q;
  assign rnd     = (size_q + ROUND_MASK) & ~ROUND_MASK;
  assign sum     = {1'b0, aref_q} + {1'b0, sz_q};

  sfla_chunk_mem u_chunk_mem (
    .clk_i   (clk_i),
    .we_i    (cw_we),
    .waddr_i (cw_addr),
    .wdata_i (cw_data),
    .raddr_i (cr_addr),
    .rdata_o (cr_data)
  );

  always_ff @(posedge clk_i) begin
    if (sw_we) begin
      slab_q[sw_addr] <= sw_data;
    end
    sl_rd_q <= slab_q[sr_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      trk_q   <= TRK_CLEAN;
      base_q  <= BASE_RESET;
      fcnt_q  <= '0;
      rcnt_q  <= '0;
      scnt_q  <= '0;
    end else begin
      state_q <= state_d;
      trk_q   <= trk_d;
      fcnt_q  <= fcnt_d;
      rcnt_q  <= rcnt_d;
      scnt_q  <= scnt_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    m_q      <= m_d;
    sk_q     <= sk_d;
    tbl_q    <= tbl_d;
    ref_q    <= ref_d;
    size_q   <= size_d;
    end_q    <= end_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    sz_q     <= sz_d;
    aref_q   <= aref_d;
    mlen_q   <= mlen_d;
    res_q    <= res_d;
    merged_q <= merged_d;
    se_end_q <= se_end_d;
    se_ref_q <= se_ref_d;
    full_q   <= full_d;
    chk_q    <= chk_d;
  end

  always_comb begin
    state_d  = state_q;
    trk_d    = trk_q;
    fcnt_d   = fcnt_q;
    rcnt_d   = rcnt_q;
    scnt_d   = scnt_q;
    k_d      = k_q;
    m_d      = m_q;
    sk_d     = sk_q;
    tbl_d    = tbl_q;
    ref_d    = ref_q;
    size_d   = size_q;
    end_d    = end_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    sz_d     = sz_q;
    aref_d   = aref_q;
    mlen_d   = mlen_q;
    res_d    = res_q;
    merged_d = merged_q;
    se_end_d = se_end_q;
    se_ref_d = se_ref_q;
    full_d   = full_q;
    chk_d    = chk_q;
    cw_we    = 1'b0;
    cw_addr  = {tbl_q, k_q};
    cw_data  = cr_data;
    cr_addr  = {tbl_q, k_q};
    sw_we    = 1'b0;
    sw_addr  = scnt_q[SIDX_W-1:0];
    sw_data  = sum[ADDR_W-1:0];
    sr_addr  = sk_q;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          ref_d    = s_ref;
          size_d   = s_size;
          end_d    = s_ref + s_size;
          res_d    = '0;
          full_d   = 1'b0;
          chk_d    = 1'b1;
          merged_d = 1'b0;
          se_end_d = 1'b0;
          se_ref_d = 1'b0;
          tbl_d    = 1'b0;
          k_d      = '0;
          sk_d     = '0;
          case (s_cmd)
            CMD_ALLOC: begin
              if (trk_q == TRK_INVALID) begin
                state_d = S_RESP;
              end else begin
                trk_d = TRK_DIRTY;
                if (fcnt_q == '0) begin
                  state_d = S_A_SLAB0;
                end else begin
                  k_d     = FIDX_W'(fcnt_q - FCNT_W'(1));
                  state_d = S_A_RD;
                end
              end
            end
            CMD_FREE: begin
              tbl_d = s_ref < base_q;
              if (trk_q == TRK_INVALID) begin
                state_d = S_RESP;
              end else begin
                trk_d   = TRK_DIRTY;
                state_d = (scnt_q == '0) ? S_F_S1_GO : S_F_SE_RD;
              end
            end
            CMD_REBUILD: begin
              if (trk_q == TRK_CLEAN) begin
                state_d = S_RESP;
              end else begin
                fcnt_d  = '0;
                rcnt_d  = '0;
                trk_d   = TRK_CLEAN;
                cur_d   = base_q;
                state_d = (scnt_q == '0) ? S_RESP : S_R_RD;
              end
            end
            default: begin
              chk_d   = 1'b0;
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_A_RD: state_d = S_A_CHK;

      S_A_CHK: begin
        if (size_q <= cr_data.len) begin
          res_d = cr_data.start;
          if (cr_data.len == size_q) begin
            state_d = S_A_LAST_RD;
          end else begin
            cw_we         = 1'b1;
            cw_data.len   = cr_data.len - size_q;
            cw_data.start = cr_data.start + size_q;
            state_d       = S_RESP;
          end
        end else if (k_q == '0) begin
          state_d = S_A_SLAB0;
        end else begin
          k_d     = k_q - FIDX_W'(1);
          state_d = S_A_RD;
        end
      end

      // exact fit: the last entry moves into the hole
      S_A_LAST_RD: begin
        cr_addr = {1'b0, FIDX_W'(fcnt_q - FCNT_W'(1))};
        state_d = S_A_LAST_WR;
      end

      S_A_LAST_WR: begin
        cw_we   = 1'b1;
        fcnt_d  = fcnt_q - FCNT_W'(1);
        state_d = S_RESP;
      end

      S_A_SLAB0: begin
        if (scnt_q == SCNT_W'(SLAB_ENTRIES) || size_q > ~ROUND_MASK) begin
          full_d  = 1'b1;
          state_d = S_RESP;
        end else if (scnt_q == '0) begin
          aref_d  = base_q;
          sz_d    = rnd;
          state_d = S_A_SLAB_WR;
        end else begin
          sr_addr = SIDX_W'(scnt_q - SCNT_W'(1));
          state_d = S_A_SLAB1;
        end
      end

      S_A_SLAB1: begin
        cur_d = sl_rd_q;
        if (scnt_q == SCNT_W'(1)) begin
          prev_d  = base_q;
          state_d = S_A_CALC;
        end else begin
          sr_addr = SIDX_W'(scnt_q - SCNT_W'(2));
          state_d = S_A_SLAB2;
        end
      end

      S_A_SLAB2: begin
        prev_d  = sl_rd_q;
        state_d = S_A_CALC;
      end

      // new slab is at least twice the previous one
      S_A_CALC: begin
        if (diff[ADDR_W-1]) begin
          full_d  = 1'b1;
          state_d = S_RESP;
        end else begin
          sz_d    = (rnd < {diff[ADDR_W-2:0], 1'b0}) ? {diff[ADDR_W-2:0], 1'b0} : rnd;
          aref_d  = cur_q;
          state_d = S_A_SLAB_WR;
        end
      end

      S_A_SLAB_WR: begin
        if (sum[ADDR_W]) begin
          full_d  = 1'b1;
          state_d = S_RESP;
        end else begin
          sw_we   = 1'b1;
          scnt_d  = scnt_q + SCNT_W'(1);
          res_d   = aref_q;
          state_d = (sz_q > size_q) ? S_A_APPEND : S_RESP;
        end
      end

      S_A_APPEND: begin
        cw_addr       = {1'b0, fcnt_q[FIDX_W-1:0]};
        cw_data.len   = sz_q - size_q;
        cw_data.start = aref_q + size_q;
        if (fcnt_q < FCNT_W'(FREE_ENTRIES)) begin
          cw_we  = 1'b1;
          fcnt_d = fcnt_q + FCNT_W'(1);
        end else begin
          trk_d = TRK_INVALID;
        end
        state_d = S_RESP;
      end

      S_F_SE_RD: state_d = S_F_SE_CHK;

      S_F_SE_CHK: begin
        if (sl_rd_q == end_q) se_end_d = 1'b1;
        if (sl_rd_q == ref_q) se_ref_d = 1'b1;
        if (sk_last) begin
          state_d = S_F_S1_GO;
        end else begin
          sk_d    = sk_q + SIDX_W'(1);
          state_d = S_F_SE_RD;
        end
      end

      S_F_S1_GO: begin
        k_d     = '0;
        state_d = (cnt_sel == '0) ? S_F_S2_GO : S_F_S1_RD;
      end

      S_F_S1_RD: state_d = S_F_S1_CHK;

      // following chunk: first one starting at the freed end
      S_F_S1_CHK: begin
        if (cr_data.start == end_q) begin
          if (!se_end_q) begin
            cw_we         = 1'b1;
            cw_data.len   = cr_data.len + size_q;
            cw_data.start = ref_q;
            merged_d      = 1'b1;
            m_d           = k_q;
            mlen_d        = cr_data.len + size_q;
          end
          state_d = S_F_S2_GO;
        end else if (k_last) begin
          state_d = S_F_S2_GO;
        end else begin
          k_d     = k_q + FIDX_W'(1);
          state_d = S_F_S1_RD;
        end
      end

      S_F_S2_GO: begin
        k_d     = '0;
        state_d = (se_ref_q || cnt_sel == '0) ? S_F_FINISH : S_F_S2_RD;
      end

      S_F_S2_RD: state_d = S_F_S2_CHK;

      // preceding chunk: one ending at the freed ref
      S_F_S2_CHK: begin
        if (!(merged_q && k_q == m_q) && (cr_data.start + cr_data.len) == ref_q) begin
          cw_we = 1'b1;
          if (merged_q) begin
            cw_data.len = cr_data.len + mlen_q;
            state_d     = S_F_MV_RD;
          end else begin
            cw_data.len = cr_data.len + size_q;
            state_d     = S_RESP;
          end
        end else if (k_last) begin
          state_d = S_F_FINISH;
        end else begin
          k_d     = k_q + FIDX_W'(1);
          state_d = S_F_S2_RD;
        end
      end

      S_F_MV_RD: begin
        cr_addr = {tbl_q, FIDX_W'(cnt_sel - FCNT_W'(1))};
        state_d = S_F_MV_WR;
      end

      S_F_MV_WR: begin
        cw_we   = 1'b1;
        cw_addr = {tbl_q, m_q};
        if (tbl_q) rcnt_d = rcnt_q - FCNT_W'(1);
        else       fcnt_d = fcnt_q - FCNT_W'(1);
        state_d = S_RESP;
      end

      S_F_FINISH: begin
        cw_addr       = {tbl_q, cnt_sel[FIDX_W-1:0]};
        cw_data.len   = size_q;
        cw_data.start = ref_q;
        if (!merged_q) begin
          if (cnt_sel < FCNT_W'(FREE_ENTRIES)) begin
            cw_we = 1'b1;
            if (tbl_q) rcnt_d = rcnt_q + FCNT_W'(1);
            else       fcnt_d = fcnt_q + FCNT_W'(1);
          end else begin
            trk_d = TRK_INVALID;
          end
        end
        state_d = S_RESP;
      end

      S_R_RD: state_d = S_R_CHK;

      // one chunk per slab, cur_q holds the running start
      S_R_CHK: begin
        cw_addr       = {1'b0, fcnt_q[FIDX_W-1:0]};
        cw_data.len   = sl_rd_q - cur_q;
        cw_data.start = cur_q;
        if (fcnt_q < FCNT_W'(FREE_ENTRIES)) begin
          cw_we  = 1'b1;
          fcnt_d = fcnt_q + FCNT_W'(1);
        end else begin
          trk_d = TRK_INVALID;
        end
        cur_d = sl_rd_q;
        if (sk_last) begin
          state_d = S_RESP;
        end else begin
          sk_d    = sk_q + SIDX_W'(1);
          state_d = S_R_RD;
        end
      end

      S_RESP: begin
        if (m_axis_tready_i) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  status_e status;
  always_comb begin
    if (full_q)                              status = ST_FULL;
    else if (chk_q && trk_q == TRK_INVALID)  status = ST_INVALID;
    else                                     status = ST_OK;
  end

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = state_q == S_RESP;
  assign m_axis_tdata_o  = {6'b0, status, res_q};

endmodule
